[src/ier_pkg.sv]
// Shared types, constants and table builders for the ICMP echo request generator.
// No dependencies; every other source file of the block uses this package.
package ier_pkg;

   localparam int unsigned HDR_BYTES    = 8;
   localparam int unsigned LETTER_COUNT = 26;
   localparam int unsigned OFFSET_COUNT = 13;   // 4*seq mod 26 is always even
   localparam int unsigned RECIP_13     = 5041; // floor(2^16 / 13)
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam logic [7:0]  ECHO_TYPE    = 8'h08;
   localparam logic [7:0]  ECHO_CODE    = 8'h00;
   localparam logic [7:0]  LETTER_BASE  = 8'h41;

   typedef logic [15:0] word_type;
   typedef logic [7:0]  byte_type;
   typedef logic [3:0]  offset_type;
   typedef logic [4:0]  letter_type;
   typedef word_type [OFFSET_COUNT-1:0] sum_table_type;

   typedef enum logic [2:0] {
      HDR_TYPE,
      HDR_CODE,
      HDR_CSUM_HI,
      HDR_CSUM_LO,
      HDR_ID_HI,
      HDR_ID_LO,
      HDR_SEQ_HI,
      HDR_SEQ_LO
   } hdr_pos_type;

   typedef struct packed {
      word_type   seq;
      offset_type offset;    // payload starts at letter 2*offset
      word_type   checksum;
   } job_type;

   // Folded ones-complement sum of the payload words for a given start letter.
   function automatic word_type payload_sum(int unsigned start, int unsigned nbytes);
      int unsigned acc;
      int unsigned letter;
      acc    = 0;
      letter = start;
      for (int unsigned i = 0; i < nbytes; i++) begin
         if ((i & 1) == 0) begin
            acc = acc + ((int'(LETTER_BASE) + letter) << 8);
         end else begin
            acc = acc + (int'(LETTER_BASE) + letter);
         end
         letter = (letter == LETTER_COUNT - 1) ? 0 : letter + 1;
      end
      acc = (acc & 32'h0000_ffff) + (acc >> 16);
      acc = (acc & 32'h0000_ffff) + (acc >> 16);
      return word_type'(acc);
   endfunction

   function automatic sum_table_type build_sum_table(int unsigned nbytes);
      sum_table_type tbl;
      for (int unsigned t = 0; t < OFFSET_COUNT; t++) begin
         tbl[t] = payload_sum(2 * t, nbytes);
      end
      return tbl;
   endfunction

endpackage

[src/ier_req_if.sv]
// Request channel: one sequence number per transfer.
// Depends on ier_pkg for the word type.
interface ier_req_if;
   logic                valid;
   logic                ready;
   ier_pkg::word_type   sequence_number;

   modport source (output valid, output sequence_number, input ready);
   modport sink   (input valid, input sequence_number, output ready);
endinterface

[src/ier_rsp_if.sv]
// Response channel: one message byte per transfer, with a last-byte flag.
// Depends on ier_pkg for the byte type.
interface ier_rsp_if;
   logic                valid;
   logic                ready;
   ier_pkg::byte_type   packet_byte;
   logic                last_byte;

   modport source (output valid, output packet_byte, output last_byte, input ready);
   modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

[src/ier_front.sv]
// Front end: takes requests, finds the payload start letter and the checksum.
// Three-stage pipeline; depends on ier_pkg.
module ier_front #(
   parameter int unsigned PAYLOAD_BYTES = 56
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ier_pkg::word_type   in_seq,
   input  ier_pkg::word_type   echo_id,
   output logic                job_valid,
   input  logic                job_ready,
   output ier_pkg::job_type    job
);
   import ier_pkg::*;

   localparam sum_table_type SUM_TABLE = build_sum_table(PAYLOAD_BYTES);
   localparam word_type      HDR_WORD  = {ECHO_TYPE, ECHO_CODE};

   logic                v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                rdy1, rdy2, rdy3;
   word_type            seq1_ff, seq1_in, seq2_ff, seq2_in, seq3_ff, seq3_in;
   logic [28:0]         prod1_ff, prod1_in;
   offset_type          rem2_ff, rem2_in;
   offset_type          off3_ff, off3_in;
   logic [17:0]         total3_ff, total3_in;

   logic [12:0]         quot;
   word_type            rem_wide;
   letter_type          rem_raw;
   letter_type          twice;
   offset_type          offset_c;
   logic [16:0]         fold1;
   word_type            fold2;

   assign rdy3     = !v3_ff || job_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      // stage 1: seq * floor(2^16/13), quotient may come out one low
      seq1_in  = rdy1 ? in_seq : seq1_ff;
      prod1_in = rdy1 ? 29'(in_seq) * 29'(RECIP_13) : prod1_ff;
      v1_in    = rdy1 ? in_valid : v1_ff;

      // stage 2: seq mod 13 with one correction
      quot     = prod1_ff[28:16];
      rem_wide = seq1_ff - (16'(quot) * 16'(OFFSET_COUNT));
      rem_raw  = rem_wide[4:0];
      if (rem_raw >= letter_type'(OFFSET_COUNT)) begin
         rem_raw = rem_raw - letter_type'(OFFSET_COUNT);
      end
      seq2_in  = rdy2 ? seq1_ff : seq2_ff;
      rem2_in  = rdy2 ? rem_raw[3:0] : rem2_ff;
      v2_in    = rdy2 ? v1_ff : v2_ff;

      // stage 3: offset = 2*seq mod 13, then raw message sum
      twice = {rem2_ff, 1'b0};
      if (twice >= letter_type'(OFFSET_COUNT)) begin
         twice = twice - letter_type'(OFFSET_COUNT);
      end
      offset_c  = twice[3:0];
      seq3_in   = rdy3 ? seq2_ff : seq3_ff;
      off3_in   = rdy3 ? offset_c : off3_ff;
      total3_in = rdy3 ? (18'(HDR_WORD) + 18'(echo_id) + 18'(seq2_ff)
                          + 18'(SUM_TABLE[offset_c])) : total3_ff;
      v3_in     = rdy3 ? v2_ff : v3_ff;

      // fold end-around carries and complement
      fold1 = 17'(total3_ff[15:0]) + 17'(total3_ff[17:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
   end

   assign job_valid    = v3_ff;
   assign job.seq      = seq3_ff;
   assign job.offset   = off3_ff;
   assign job.checksum = ~fold2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      seq1_ff   <= seq1_in;
      prod1_ff  <= prod1_in;
      seq2_ff   <= seq2_in;
      rem2_ff   <= rem2_in;
      seq3_ff   <= seq3_in;
      off3_ff   <= off3_in;
      total3_ff <= total3_in;
   end

   a_off_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> off3_ff < offset_type'(OFFSET_COUNT))
      else $error("payload offset out of range");

endmodule

[src/ier_queue.sv]
// Short job queue between front end and byte streamer.
// Flip-flop storage; depends on ier_pkg.
module ier_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ier_pkg::job_type    push_job,
   output logic                pop_valid,
   input  logic                pop,
   output ier_pkg::job_type    pop_job
);
   import ier_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in    = do_push ? bump(wr_ff) : wr_ff;
      rd_in    = do_pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

endmodule

[src/ier_back.sv]
// Byte streamer: turns one queued job into the full message, one byte a cycle while the receiver is ready.
// Registered output stage; depends on ier_pkg.
module ier_back #(
   parameter int unsigned PAYLOAD_BYTES = 56
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_pop,
   input  ier_pkg::job_type    job,
   input  ier_pkg::word_type   echo_id,
   output logic                out_valid,
   input  logic                out_ready,
   output ier_pkg::byte_type   out_byte,
   output logic                out_last
);
   import ier_pkg::*;

   localparam int unsigned MSG_BYTES = HDR_BYTES + PAYLOAD_BYTES;
   localparam int unsigned IDX_W     = $clog2(MSG_BYTES);

   logic                active_ff, active_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   letter_type          letter_ff, letter_in;
   job_type             job_ff, job_in;
   logic                valid_ff, valid_in;
   byte_type            byte_ff, byte_in;
   logic                last_ff, last_in;

   logic                out_free, emit, at_last, load, in_payload;
   byte_type            cur_byte;

   assign out_free   = !valid_ff || out_ready;
   assign emit       = active_ff && out_free;
   assign at_last    = idx_ff == IDX_W'(MSG_BYTES - 1);
   assign load       = job_valid && (!active_ff || (emit && at_last));
   assign in_payload = idx_ff >= IDX_W'(HDR_BYTES);
   assign job_pop    = load;

   always_comb begin
      cur_byte = LETTER_BASE + byte_type'(letter_ff);
      if (!in_payload) begin
         unique case (hdr_pos_type'(idx_ff[2:0]))
            HDR_TYPE:    cur_byte = ECHO_TYPE;
            HDR_CODE:    cur_byte = ECHO_CODE;
            HDR_CSUM_HI: cur_byte = job_ff.checksum[15:8];
            HDR_CSUM_LO: cur_byte = job_ff.checksum[7:0];
            HDR_ID_HI:   cur_byte = echo_id[15:8];
            HDR_ID_LO:   cur_byte = echo_id[7:0];
            HDR_SEQ_HI:  cur_byte = job_ff.seq[15:8];
            HDR_SEQ_LO:  cur_byte = job_ff.seq[7:0];
         endcase
      end
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      letter_in = letter_ff;
      job_in    = job_ff;
      if (emit) begin
         idx_in = idx_ff + 1'b1;
         if (in_payload) begin
            letter_in = (letter_ff == letter_type'(LETTER_COUNT - 1)) ? '0
                                                                      : letter_ff + 1'b1;
         end
         if (at_last) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in = 1'b1;
         idx_in    = '0;
         letter_in = {job.offset, 1'b0};
         job_in    = job;
      end

      valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      byte_in  = emit ? cur_byte : byte_ff;
      last_in  = emit ? at_last : last_ff;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      job_ff    <= job_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> letter_ff < letter_type'(LETTER_COUNT))
      else $error("payload letter out of range");
   a_last_ends_msg: assert property (@(posedge clock) disable iff (reset)
      (emit && at_last) |=> (!active_ff || idx_ff == '0))
      else $error("message kept running past its last byte");

endmodule

[src/icmp_echo_request_generator.sv]
// Top level of the ICMP echo request generator: identifier register,
// front end, job queue and byte streamer. Depends on ier_pkg and both channel interfaces.
//
// Usage:
//   req_bus   - one transfer per echo request, carrying the 16-bit sequence number.
//   rsp_bus   - the complete ICMP echo request, 8 + PAYLOAD_BYTES byte transfers in
//               network order; last_byte marks the final byte of each message.
//   csr_we/csr_wdata - write the echo identifier; write it only while no message
//               is pending or in flight.
// Path: on an empty block the first byte of a message passes the three front-end stages,
//   the queue, the streamer's job register and the output register.
// Throughput: one byte per cycle while the receiver is ready, set by the byte streamer.
//   Messages follow each other with no gap; the front end keeps taking requests
//   until its pipeline and the two-entry queue are full.
// Reset: clears all valid flags, the queue and the identifier (to zero).
// Stall: when the receiver drops ready, hold the output byte; the streamer waits,
//   the queue fills, and req_bus.ready falls once the front end backs up.
module icmp_echo_request_generator #(
   parameter int unsigned PAYLOAD_BYTES = 56
) (
   input  logic                clock,
   input  logic                reset,
   ier_req_if.sink             req_bus,
   ier_rsp_if.source           rsp_bus,
   input  logic                csr_we,
   input  ier_pkg::word_type   csr_wdata
);
   import ier_pkg::*;

   word_type   id_ff, id_in;

   logic       job_valid, job_ready;
   job_type    job_front;
   logic       q_valid, q_pop;
   job_type    job_back;

   // Identifier register: take a write whenever the enable is high.
   assign id_in = csr_we ? csr_wdata : id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= '0;
      end else begin
         id_ff <= id_in;
      end
   end

   // Front end: offset of the payload letters and the checksum per request.
   ier_front #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_seq    (req_bus.sequence_number),
      .echo_id   (id_ff),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job_front)
   );

   // Decouple the front end from the streamer so either side may stall.
   ier_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_ready (job_ready),
      .push_job   (job_front),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_job    (job_back)
   );

   // Streamer: one message byte per response transfer.
   ier_back #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_pop   (q_pop),
      .job       (job_back),
      .echo_id   (id_ff),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_byte  (rsp_bus.packet_byte),
      .out_last  (rsp_bus.last_byte)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (rsp_bus.valid && $stable(rsp_bus.packet_byte)))
      else $error("response byte changed while stalled");
   a_id_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> id_ff == $past(csr_wdata))
      else $error("identifier write lost");

endmodule

[dv/tb_icmp_echo_request_generator.sv]
`timescale 1ns / 100ps
// Self-checking bench for icmp_echo_request_generator: drives sequence numbers, predicts
// each 64-byte echo request with its checksum, and compares every byte. Depends on ier_pkg,
// ier_req_if, ier_rsp_if and the block itself.
module tb_icmp_echo_request_generator;
   import ier_pkg::*;

   localparam int unsigned PAYLOAD_BYTES = 56;
   localparam int unsigned MSG_BYTES     = HDR_BYTES + PAYLOAD_BYTES;
   // Give the tail a comfortable margin once everything owed has arrived.
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned LIMIT_CYCLES  = 1000000;
   localparam int unsigned PRINT_CAP     = 30;

   typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   typedef struct {
      byte_type    data;
      logic        last;
      word_type    seq;
      int unsigned pos;
   } echo_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we = 1'b0;
   word_type    csr_wdata = '0;

   ier_req_if req_bus ();
   ier_rsp_if rsp_bus ();

   icmp_echo_request_generator #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Sequence numbers still to be offered, and the message bytes owed by the block.
   word_type      seq_backlog[$];
   echo_byte_type echo_bytes_due[$];

   // Bench copy of the identifier register.
   word_type      echo_id = '0;

   // Knobs the stimulus process turns between phases (changed on the falling edge).
   rx_mode_type   rx_mode = RX_STEADY;
   int unsigned   gap_limit = 0;
   int unsigned   hold_request = 0;

   int unsigned   hold_left;
   int unsigned   cycle_count = 0;
   int unsigned   fail_count = 0;
   int unsigned   requests_sent = 0;
   int unsigned   bytes_checked = 0;
   int unsigned   messages_checked = 0;
   int unsigned   id_writes = 0;

   // 4 ns period, high then low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Print one line per mismatch (capped) and count it.
   task automatic report_mismatch(string what);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // Build the full echo request for one sequence number and queue its bytes.
   // Checksum field counts as zero; an odd trailing byte forms the high half of a word.
   function automatic void build_echo_request(word_type seq);
      byte_type      msg [MSG_BYTES];
      int unsigned   acc;
      int unsigned   seq_val;
      word_type      csum;
      echo_byte_type entry;
      seq_val = seq;
      msg[int'(HDR_TYPE)]    = ECHO_TYPE;
      msg[int'(HDR_CODE)]    = ECHO_CODE;
      msg[int'(HDR_CSUM_HI)] = 8'h00;
      msg[int'(HDR_CSUM_LO)] = 8'h00;
      msg[int'(HDR_ID_HI)]   = echo_id[15:8];
      msg[int'(HDR_ID_LO)]   = echo_id[7:0];
      msg[int'(HDR_SEQ_HI)]  = seq[15:8];
      msg[int'(HDR_SEQ_LO)]  = seq[7:0];
      for (int unsigned i = 0; i < PAYLOAD_BYTES; i++) begin
         msg[HDR_BYTES + i] = LETTER_BASE + byte_type'((4 * seq_val + i) % LETTER_COUNT);
      end
      acc = 0;
      for (int unsigned k = 0; k + 1 < MSG_BYTES; k += 2) begin
         acc += {msg[k], msg[k + 1]};
      end
      if (MSG_BYTES % 2 != 0) begin
         acc += {msg[MSG_BYTES - 1], 8'h00};
      end
      while ((acc >> 16) != 0) begin
         acc = (acc & 32'h0000_ffff) + (acc >> 16);
      end
      csum = ~acc[15:0];
      msg[int'(HDR_CSUM_HI)] = csum[15:8];
      msg[int'(HDR_CSUM_LO)] = csum[7:0];
      for (int unsigned i = 0; i < MSG_BYTES; i++) begin
         entry.data = msg[i];
         entry.last = (i == MSG_BYTES - 1);
         entry.seq  = seq;
         entry.pos  = i;
         echo_bytes_due.push_back(entry);
      end
   endfunction

   // Compare one transferred byte against the oldest owed byte.
   task automatic check_byte(byte_type got_byte, logic got_last);
      echo_byte_type want;
      if (echo_bytes_due.size() == 0) begin
         report_mismatch($sformatf("byte %02h (last=%0b) with no request pending",
                                   got_byte, got_last));
         return;
      end
      want = echo_bytes_due.pop_front();
      if (got_byte !== want.data) begin
         report_mismatch($sformatf("seq %04h byte %0d: packet_byte %02h, want %02h",
                                   want.seq, want.pos, got_byte, want.data));
      end
      if (got_last !== want.last) begin
         report_mismatch($sformatf("seq %04h byte %0d: last_byte %0b, want %0b",
                                   want.seq, want.pos, got_last, want.last));
      end
      bytes_checked++;
      if (want.last) begin
         messages_checked++;
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   // Hold valid and the payload while the block refuses; predict on each transfer.
   int unsigned burst_left;
   int unsigned gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid           <= 1'b0;
         req_bus.sequence_number <= '0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            build_echo_request(req_bus.sequence_number);
            requests_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (seq_backlog.size() != 0) begin
               req_bus.valid           <= 1'b1;
               req_bus.sequence_number <= seq_backlog.pop_front();
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 8);
                  gap_left   = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the ready pattern stays independent.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request != 0) begin
         hold_left <= hold_request;
         hold_request = 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic logic rx_grant();
      case (rx_mode)
         RX_STEADY:   return 1'b1;
         RX_MOSTLY:   return $urandom_range(0, 3) != 0;
         RX_SPARSE:   return $urandom_range(0, 3) == 0;
         RX_PERIODIC: return (cycle_count % 11) < 7;
         default:     return 1'b1;
      endcase
   endfunction

   // Response monitor: check every transfer, then pick the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_byte(rsp_bus.packet_byte, rsp_bus.last_byte);
         end
         rsp_bus.ready <= (hold_left == 0) && rx_grant();
      end
   end

   // Watchdog: end the run if something hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timed out after %0d cycles, %0d bytes still owed",
                  cycle_count, echo_bytes_due.size());
         $display("tb_icmp_echo_request_generator: FAIL");
         $finish;
      end
   end

   // Stall the stimulus until everything offered has gone through, then let it settle.
   task automatic wait_drained();
      while (seq_backlog.size() != 0 || req_bus.valid || echo_bytes_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the identifier; only called with the block idle.
   task automatic write_identifier(word_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      echo_id = value;
      id_writes++;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // Drain, load a new identifier, and set the idling pattern for the next phase.
   task automatic start_phase(word_type id, rx_mode_type mode, int unsigned gap);
      wait_drained();
      write_identifier(id);
      rx_mode   = mode;
      gap_limit = gap;
   endtask

   // Mostly runs of consecutive sequence numbers (the way ping counts), some
   // wrapping through FFFF, mixed with random values and field extremes.
   task automatic queue_random(int unsigned count);
      int unsigned pick;
      int unsigned run_len;
      word_type    seq;
      while (count > 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            run_len = $urandom_range(2, 8);
            seq = ($urandom_range(0, 3) == 0) ? 16'hfffd : word_type'($urandom);
            for (int unsigned k = 0; k < run_len && count > 0; k++) begin
               seq_backlog.push_back(seq);
               seq++;
               count--;
            end
         end else if (pick < 8) begin
            seq_backlog.push_back(word_type'($urandom));
            count--;
         end else begin
            case ($urandom_range(0, 3))
               0:       seq_backlog.push_back(16'h0000);
               1:       seq_backlog.push_back(16'hffff);
               2:       seq_backlog.push_back(16'h7fff);
               default: seq_backlog.push_back(16'h8000);
            endcase
            count--;
         end
      end
   endtask

   initial begin
      // Known values on every input before the first edge.
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.sequence_number = '0;
      rsp_bus.ready           = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: identifier at its reset value, no idling on either side.
      // Sequences 0..12 walk all thirteen payload start letters; the rest hit
      // field extremes and alternating bit patterns.
      for (int unsigned s = 0; s < OFFSET_COUNT; s++) begin
         seq_backlog.push_back(word_type'(s));
      end
      seq_backlog.push_back(16'hffff);
      seq_backlog.push_back(16'h8000);
      seq_backlog.push_back(16'h7fff);
      seq_backlog.push_back(16'h5555);
      seq_backlog.push_back(16'haaaa);
      seq_backlog.push_back(16'h00ff);
      seq_backlog.push_back(16'hff00);
      seq_backlog.push_back(16'h000d);

      // All-ones identifier, receiver mostly ready, short sender gaps.
      start_phase(16'hffff, RX_MOSTLY, 3);
      queue_random(50);

      // Zero identifier, periodic receiver; pause the sender mid-phase until
      // every owed byte is out.
      start_phase(16'h0000, RX_PERIODIC, 10);
      queue_random(25);
      wait_drained();
      queue_random(25);

      // Receiver holds off for a long stretch while requests keep coming,
      // so the queue fills and the request channel backs up.
      start_phase(16'h8000, RX_STEADY, 0);
      hold_request = 600;
      queue_random(50);

      // Receiver mostly stalled.
      start_phase(16'h0001, RX_SPARSE, 2);
      queue_random(60);

      // Random identifier, back-to-back requests.
      start_phase(word_type'($urandom), RX_MOSTLY, 0);
      queue_random(60);

      // Random identifier, periodic receiver, long random gaps so the block can empty.
      start_phase(word_type'($urandom), RX_PERIODIC, 90);
      queue_random(60);

      // Tail: receiver always ready, wait for the last bytes and any stragglers.
      rx_mode = RX_STEADY;
      wait_drained();
      if (echo_bytes_due.size() != 0) begin
         report_mismatch($sformatf("%0d bytes never arrived", echo_bytes_due.size()));
      end

      $display("covered %0d echo requests over %0d identifier writes; %0d messages, %0d bytes",
               requests_sent, id_writes, messages_checked, bytes_checked);
      $display("receiver idling: steady, random, periodic, one long hold-off; %0d mismatches",
               fail_count);
      if (fail_count == 0) begin
         $display("tb_icmp_echo_request_generator: PASS");
      end else begin
         $display("tb_icmp_echo_request_generator: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
src/ier_pkg.sv
src/ier_req_if.sv
src/ier_rsp_if.sv
src/ier_front.sv
src/ier_queue.sv
src/ier_back.sv
src/icmp_echo_request_generator.sv
dv/tb_icmp_echo_request_generator.sv
